// File: design/a85_pkg.sv
// Shared constants and types for the Ascii85 stream encoder.
package a85_pkg;

  localparam int unsigned A85_DIGITS = 5;
  localparam logic [6:0] A85_BASE = 7'd85;
  localparam logic [6:0] A85_OFFSET = 7'd33;
  localparam logic [6:0] A85_ZERO_CHAR = 7'd122;
  localparam logic [31:0] A85_RECIP = 32'hC0C0C0C1;
  localparam int unsigned A85_RECIP_SHIFT = 38;
  localparam int unsigned JOB_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 2;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  ndig;
    logic        zero;
    logic        last;
  } a85_job_t;

  typedef struct packed {
    logic [6:0] chr;
    logic       last;
  } a85_char_t;

  typedef enum logic [1:0] {
    CV_IDLE,
    CV_RUN,
    CV_DONE
  } conv_state_t;

endpackage

// File: design/a85_fifo.sv
// Small first-in first-out queue of register entries.
module a85_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: design/a85_front.sv
// Byte packer that turns finished or final groups into conversion jobs.
module a85_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                job_push,
  output a85_pkg::a85_job_t   job,
  input  logic                job_full
);

  import a85_pkg::*;

  logic [23:0] group_r, group_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        accept;
  logic        group_done;
  logic [31:0] word;

  assign full       = job_full;
  assign accept     = push && !job_full;
  assign group_done = (held_r == 2'd3);
  assign word       = {group_r, data_byte};

  always_comb begin
    job.last = last_byte;
    job.ndig = 3'(held_r) + 3'd2;
    job.zero = group_done && (word == 32'd0);
    unique case (held_r)
      2'd0:    job.word = {data_byte, 24'd0};
      2'd1:    job.word = {group_r[7:0], data_byte, 16'd0};
      2'd2:    job.word = {group_r[15:0], data_byte, 8'd0};
      default: job.word = word;
    endcase
  end

  assign job_push = accept && (group_done || last_byte);

  always_comb begin
    group_nxt = group_r;
    held_nxt  = held_r;
    if (accept) begin
      if (group_done || last_byte) begin
        group_nxt = '0;
        held_nxt  = '0;
      end else begin
        group_nxt = word[23:0];
        held_nxt  = held_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_r <= '0;
      held_r  <= '0;
    end else begin
      group_r <= group_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// File: design/a85_back.sv
// Base-85 digit converter and character emitter for conversion jobs.
module a85_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_empty,
  output logic                job_pop,
  input  a85_pkg::a85_job_t   job,
  output logic                ch_push,
  output a85_pkg::a85_char_t  ch,
  input  logic                ch_full
);

  import a85_pkg::*;

  conv_state_t cv_state_r, cv_state_nxt;
  logic [31:0] w_r;
  logic [2:0]  cnt_r;
  logic [6:0]  dig_r [A85_DIGITS];
  logic [2:0]  cv_ndig_r;
  logic        cv_zero_r;
  logic        cv_last_r;

  logic        em_busy_r;
  logic [2:0]  em_left_r;
  logic        em_zero_r;
  logic        em_last_r;
  logic [6:0]  em_dig_r [A85_DIGITS];

  logic [63:0] prod;
  logic [25:0] quot;
  logic [6:0]  q85;
  logic [6:0]  rem;
  logic        step;
  logic        hand;
  logic        ch_go;

  // Division by 85 through a reciprocal; the remainder fits in seven bits.
  assign prod = 64'(w_r) * 64'(A85_RECIP);
  assign quot = prod[63:A85_RECIP_SHIFT];
  assign q85  = 7'(quot[6:0] * A85_BASE);
  assign rem  = w_r[6:0] - q85;

  always_comb begin
    cv_state_nxt = cv_state_r;
    unique case (cv_state_r)
      CV_IDLE: begin
        if (!job_empty) begin
          cv_state_nxt = job.zero ? CV_DONE : CV_RUN;
        end
      end
      CV_RUN: begin
        if (cnt_r == 3'(A85_DIGITS - 1)) begin
          cv_state_nxt = CV_DONE;
        end
      end
      CV_DONE: begin
        if (!em_busy_r) begin
          cv_state_nxt = CV_IDLE;
        end
      end
      default: cv_state_nxt = CV_IDLE;
    endcase
  end

  always_comb begin
    job_pop = 1'b0;
    step    = 1'b0;
    hand    = 1'b0;
    unique case (cv_state_r)
      CV_IDLE: job_pop = !job_empty;
      CV_RUN:  step    = 1'b1;
      CV_DONE: hand    = !em_busy_r;
      default: job_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_state_r <= CV_IDLE;
    end else begin
      cv_state_r <= cv_state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      w_r       <= job.word;
      cnt_r     <= '0;
      cv_ndig_r <= job.ndig;
      cv_zero_r <= job.zero;
      cv_last_r <= job.last;
    end else if (step) begin
      w_r      <= 32'(quot);
      cnt_r    <= cnt_r + 1'b1;
      dig_r[0] <= rem;
      for (int k = 1; k < A85_DIGITS; k++) begin
        dig_r[k] <= dig_r[k-1];
      end
    end
  end

  assign ch_push = em_busy_r;
  assign ch_go   = em_busy_r && !ch_full;
  assign ch.chr  = em_zero_r ? A85_ZERO_CHAR : em_dig_r[0] + A85_OFFSET;
  assign ch.last = em_last_r && (em_left_r == 3'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
    end else if (hand) begin
      em_busy_r <= 1'b1;
    end else if (ch_go && (em_left_r == 3'd1)) begin
      em_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hand) begin
      em_left_r <= cv_zero_r ? 3'd1 : cv_ndig_r;
      em_zero_r <= cv_zero_r;
      em_last_r <= cv_last_r;
      for (int k = 0; k < A85_DIGITS; k++) begin
        em_dig_r[k] <= dig_r[k];
      end
    end else if (ch_go) begin
      em_left_r <= em_left_r - 1'b1;
      for (int k = 0; k < A85_DIGITS - 1; k++) begin
        em_dig_r[k] <= em_dig_r[k+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_digits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cv_state_r == CV_DONE && !cv_zero_r) |->
      (dig_r[0] < A85_BASE) && (dig_r[2] < A85_BASE) && (dig_r[4] < A85_BASE))
    else $error("Converted digit is not below the base.");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    em_busy_r |-> (em_left_r != 3'd0) && (em_left_r <= 3'(A85_DIGITS)))
    else $error("Emitter is busy with no characters left.");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (ch_go && (em_left_r == 3'd1)) |=> !em_busy_r)
    else $error("Emitter stayed busy after its final character.");
`endif

endmodule

// File: design/ascii85_stream_encoder.sv
// Ascii85 stream encoder top level: byte packer, job queue, converter and output queue.
// Bytes are taken whenever full is low; a byte that completes a group or ends the stream
// becomes a job in a two-entry queue, so the packer keeps accepting while the converter
// works. The converter loads a job, computes its digits (one 32x32 reciprocal multiply per
// digit, the unit that sets the pace) and hands the digits to the emitter once the emitter
// is free; an all-zero group skips the digit steps. The emitter writes one character per
// cycle into a two-entry output queue, holding while that queue is full, and meanwhile the
// converter already works on the next job.
module ascii85_stream_encoder #(
  parameter int unsigned JOB_DEPTH = a85_pkg::JOB_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = a85_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       empty,
  input  logic       pop,
  output logic [6:0] out_char,
  output logic       out_last_char
);

  import a85_pkg::*;

  a85_job_t  job_in, job_out;
  a85_char_t ch_in, ch_out;
  logic      job_push, job_full, job_pop, job_empty;
  logic      ch_push, ch_full;

  a85_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .job_push  (job_push),
    .job       (job_in),
    .job_full  (job_full)
  );

  a85_fifo #(
    .WIDTH ($bits(a85_job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  a85_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job       (job_out),
    .ch_push   (ch_push),
    .ch        (ch_in),
    .ch_full   (ch_full)
  );

  a85_fifo #(
    .WIDTH ($bits(a85_char_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ch_push),
    .wdata (ch_in),
    .full  (ch_full),
    .pop   (pop),
    .rdata (ch_out),
    .empty (empty)
  );

  assign out_char      = ch_out.chr;
  assign out_last_char = ch_out.last;

endmodule

// File: tb/ascii85_stream_encoder_test.sv
// Self-checking testbench for the Ascii85 stream encoder: directed table, random streams, stalls.
`timescale 1ns / 1ps

module ascii85_stream_encoder_test;
  import a85_pkg::*;

  typedef struct {
    logic [7:0]  b;
    logic        l;
    int          n;
    logic [39:0] txt;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       empty;
  logic       pop;
  logic [6:0] out_char;
  logic       out_last_char;

  logic [31:0] grp_word;
  logic [1:0]  grp_count;
  a85_char_t   pending_chars[$];
  int          errors;
  int          items_sent;
  bit          send_calm;
  bit          recv_calm;
  bit          hold_req;
  bit          hold_active;

  // Rows with a nonzero count carry the expected characters as text; the rest use the predictor.
  dir_row_t dir_rows [21] = '{
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b1, 1, "z"},
    '{8'hFF, 1'b0, 0, 40'h0},
    '{8'hFF, 1'b0, 0, 40'h0},
    '{8'hFF, 1'b0, 0, 40'h0},
    '{8'hFF, 1'b0, 5, "s8W-!"},
    '{8'h00, 1'b1, 2, "!!"},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b1, 3, "!!!"},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b1, 4, "!!!!"},
    '{8'hFF, 1'b0, 0, 40'h0},
    '{8'hFF, 1'b0, 0, 40'h0},
    '{8'hFF, 1'b1, 0, 40'h0},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h00, 1'b0, 0, 40'h0},
    '{8'h01, 1'b0, 0, 40'h0}
  };

  ascii85_stream_encoder uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .empty        (empty),
    .pop          (pop),
    .out_char     (out_char),
    .out_last_char(out_last_char)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int encode_byte(input logic [7:0] b, input logic l,
                                     output a85_char_t res [5]);
    logic [31:0] w;
    logic [2:0]  cnt;
    int          n;
    cnt = {1'b0, grp_count} + 3'd1;
    w = {grp_word[23:0], b};
    for (int k = 0; k < 5; k++) begin
      res[k] = '0;
    end
    if (cnt < 3'd4 && !l) begin
      grp_word = w;
      grp_count = cnt[1:0];
      return 0;
    end
    grp_word = '0;
    grp_count = '0;
    if (cnt == 3'd4 && w == 32'd0) begin
      res[0].chr = A85_ZERO_CHAR;
      res[0].last = l;
      return 1;
    end
    if (cnt < 3'd4) begin
      w = w << (8 * (4 - cnt));
    end
    n = cnt + 1;
    for (int k = 4; k >= 0; k--) begin
      res[k].chr = 7'(w % 32'(A85_BASE)) + A85_OFFSET;
      w = w / 32'(A85_BASE);
    end
    for (int k = 0; k < n; k++) begin
      res[k].last = l && (k == n - 1);
    end
    return n;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic l, input int n,
                           input logic [39:0] txt);
    int        gap;
    int        got;
    a85_char_t res [5];
    a85_char_t c;
    @(negedge clk);
    if ($urandom_range(0, 19) == 0) begin
      send_calm = !send_calm;
    end
    gap = (send_calm || hold_req || hold_active) ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_data_byte = b;
    in_last_byte = l;
    do @(posedge clk); while (full);
    items_sent++;
    got = encode_byte(b, l, res);
    if (n > 0) begin
      for (int k = 0; k < n; k++) begin
        c.chr = txt[8 * (n - 1 - k) +: 7];
        c.last = l && (k == n - 1);
        pending_chars.push_back(c);
      end
    end else begin
      for (int k = 0; k < got; k++) begin
        pending_chars.push_back(res[k]);
      end
    end
  endtask

  initial begin
    int         len;
    logic       zero_grp;
    logic [7:0] b;
    bit         held;
    bit         drained;
    rst_n = 1'b0;
    push = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    grp_word = '0;
    grp_count = '0;
    errors = 0;
    items_sent = 0;
    send_calm = 1'b0;
    hold_req = 1'b0;
    hold_active = 1'b0;
    held = 1'b0;
    drained = 1'b0;
    zero_grp = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].b, dir_rows[i].l, dir_rows[i].n, dir_rows[i].txt);
    end

    while (items_sent < 170) begin
      if (!held && items_sent >= 50) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if (!drained && items_sent >= 110) begin
        @(negedge clk);
        push = 1'b0;
        while (pending_chars.size() != 0) @(posedge clk);
        drained = 1'b1;
      end
      len = $urandom_range(1, 14);
      for (int i = 0; i < len; i++) begin
        if (i % 4 == 0) begin
          zero_grp = ($urandom_range(0, 4) == 0);
        end
        case ($urandom_range(0, 5))
          0: b = 8'h00;
          1: b = 8'hFF;
          default: b = 8'($urandom_range(0, 255));
        endcase
        if (zero_grp) begin
          b = 8'h00;
        end
        send_item(b, i == len - 1, 0, 40'h0);
      end
    end

    @(negedge clk);
    push = 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    int        gap;
    a85_char_t want;
    pop = 1'b0;
    recv_calm = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_active = 1'b1;
        pop = 1'b0;
        repeat (120) @(negedge clk);
        hold_active = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) begin
        recv_calm = !recv_calm;
      end
      gap = recv_calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected result, expected none, got char %0d last %0b",
                 $time, out_char, out_last_char);
        errors++;
      end else begin
        want = pending_chars.pop_front();
        if (out_char !== want.chr) begin
          $display("%0t: out_char mismatch, expected %0d, got %0d",
                   $time, want.chr, out_char);
          errors++;
        end
        if (out_last_char !== want.last) begin
          $display("%0t: out_last_char mismatch, expected %0b, got %0b",
                   $time, want.last, out_last_char);
          errors++;
        end
      end
    end
  end

  initial begin
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
